// File: hdl/bed_pkg.sv
// Shared types, codes and helpers for the button event detector.
package bed_pkg;

    // Button phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_UP   = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    // What the last press left behind
    typedef enum logic [1:0] {
        PR_NONE  = 2'd0,
        PR_CLICK = 2'd1,
        PR_WAIT  = 2'd2,
        PR_LONG  = 2'd3
    } prior_t;

    // Kind of the press in progress
    typedef enum logic [1:0] {
        PK_NONE   = 2'd0,
        PK_SHORT  = 2'd1,
        PK_DOUBLE = 2'd2,
        PK_LONG   = 2'd3
    } kind_t;

    // Reported event codes
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CLICK    = 3'd1,
        EV_DOUBLE   = 3'd2,
        EV_LONG     = 3'd3,
        EV_LONG_REL = 3'd4
    } event_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_LONG       = 3'd1,
        CFG_REPEAT     = 3'd2,
        CFG_DOUBLE     = 3'd3,
        CFG_ACTIVE     = 3'd4,
        CFG_LONG_REL   = 3'd5,
        CFG_DELAYED    = 3'd6
    } cfg_idx_t;

    localparam logic [7:0] SAT_MAX = 8'hFF;

    // Per-button state record, one memory word
    typedef struct packed {
        logic [7:0] gap_count;
        logic [7:0] repeat_count;
        logic [7:0] hold_count;
        kind_t      press_kind;
        prior_t     prior_phase;
        phase_t     phase;
        logic [7:0] debounce_count;
        logic       stable_level;
    } btn_state_t;

    // Timing and mode settings handed to the update logic
    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] long_ticks;
        logic [7:0] repeat_ticks;
        logic [7:0] double_ticks;
        logic       long_on_release;
        logic       delayed_single;
    } bed_cfg_t;

    // Saturating 8-bit increment
    function automatic logic [7:0] inc_sat(input logic [7:0] v);
        return (v == SAT_MAX) ? SAT_MAX : 8'(v + 8'd1);
    endfunction

endpackage

// File: hdl/bed_update.sv
// Next-state and event logic for one button tick.
module bed_update
    import bed_pkg::*;
(
    input  btn_state_t cur,
    input  logic       level,
    input  logic       active_level,
    input  bed_cfg_t   cfg,
    output btn_state_t nxt,
    output event_t     event_res
);

    logic [7:0] cnt;

    always_comb
    begin
        nxt       = cur;
        event_res = EV_NONE;
        cnt       = 8'd0;

        // Debounce: count ticks that differ from the debounced level
        if (level != cur.stable_level)
        begin
            cnt = inc_sat(cur.debounce_count);
            nxt.debounce_count = cnt;
            if (cnt >= cfg.debounce_ticks)
            begin
                nxt.stable_level   = level;
                nxt.debounce_count = 8'd0;
                if (cur.phase == PH_IDLE || cur.phase == PH_WAIT)
                    nxt.phase = PH_DOWN;
                else if (cur.phase == PH_DOWN)
                    nxt.phase = PH_UP;
            end
        end

        // Phase handling on the updated phase
        unique case (nxt.phase)
            PH_DOWN:
            begin
                if (nxt.stable_level == active_level)
                begin
                    if (cur.press_kind != PK_LONG)
                        nxt.press_kind = PK_SHORT;
                    nxt.hold_count = inc_sat(cur.hold_count);
                    if (nxt.hold_count >= cfg.long_ticks)
                    begin
                        if (cfg.long_on_release)
                            nxt.press_kind = PK_LONG;
                        else
                        begin
                            nxt.repeat_count = inc_sat(cur.repeat_count);
                            if (nxt.repeat_count >= cfg.repeat_ticks)
                            begin
                                nxt.repeat_count = 8'd0;
                                nxt.press_kind   = PK_LONG;
                                event_res        = EV_LONG;
                            end
                        end
                    end
                end
            end
            PH_UP:
            begin
                if (cur.press_kind == PK_SHORT)
                begin
                    nxt.hold_count   = 8'd0;
                    nxt.repeat_count = 8'd0;
                    if (cur.gap_count <= cfg.double_ticks && cur.prior_phase == PR_WAIT)
                    begin
                        nxt.press_kind  = PK_DOUBLE;
                        event_res       = EV_DOUBLE;
                        nxt.phase       = PH_IDLE;
                        nxt.prior_phase = PR_NONE;
                    end
                    else
                    begin
                        nxt.gap_count = 8'd0;
                        if (!cfg.delayed_single)
                            event_res = EV_CLICK;
                        nxt.phase       = PH_WAIT;
                        nxt.prior_phase = PR_WAIT;
                    end
                end
                else if (cur.press_kind == PK_LONG)
                begin
                    event_res        = cfg.long_on_release ? EV_LONG : EV_LONG_REL;
                    nxt.hold_count   = 8'd0;
                    nxt.repeat_count = 8'd0;
                    nxt.press_kind   = PK_NONE;
                    nxt.phase        = PH_IDLE;
                    nxt.prior_phase  = PR_LONG;
                end
                else
                begin
                    nxt.phase = PH_IDLE;
                end
            end
            PH_WAIT:
            begin
                nxt.gap_count = inc_sat(cur.gap_count);
                if (nxt.gap_count >= cfg.double_ticks)
                begin
                    nxt.phase       = PH_IDLE;
                    nxt.prior_phase = PR_NONE;
                    if (cfg.delayed_single)
                    begin
                        nxt.gap_count   = 8'd0;
                        event_res       = EV_CLICK;
                        nxt.prior_phase = PR_CLICK;
                    end
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hdl/button_event_detector_top.sv
// Top level of the button event detector: state memory, pipeline, output register.
//
//  Channel  Dir  Signals                     Contents
//  -------  ---  --------------------------  ---------------------------------------
//  s_*      in   s_tvalid s_tready s_tdata   poll tick: button, raw level
//  m_*      out  m_tvalid m_tready m_tdata   result: button_out, event_res, phase
//  cfg_*    in   cfg_valid cfg_ready ...     register write: cfg_index, cfg_data
//
//  One tick per cycle unless the output stalls; each result is registered onto m_tdata
//  (memory word read at the accepting edge, update and write-back as it moves to the output).
//  Same-button ticks back to back are served by forwarding the last written record.
//  Reset clears the per-button valid bits, so every button reads as all-zero state.
//  A stalled output holds the pipeline; s_tready drops only when the update stage is full
//  and its result cannot move into the output register.
module button_event_detector_top
    import bed_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [2:0] button, [3] level, [7:4] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [2:0] button_out, [5:3] event_res, [7:6] phase
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Configuration registers
    logic [7:0] debounce_reg, long_reg, repeat_reg, double_reg, active_reg;
    logic       long_rel_reg, delayed_reg;
    bed_cfg_t   cfg;

    // State memory and valid bits
    btn_state_t              mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]  entry_valid_reg;
    btn_state_t              rd_data_reg;
    logic                    rd_valid_reg;

    // Update stage
    logic              s1_valid_reg;
    logic [2:0]        s1_button_reg;
    logic              s1_level_reg;
    logic              s1_in_range_reg;
    logic [ADDR_W-1:0] s1_addr;

    // Last write-back, for forwarding
    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    btn_state_t        wb_data_reg;

    // Output register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    logic              s_fire, s1_fire, out_room, mem_we;
    logic [2:0]        in_button;
    logic              in_level, in_range;
    logic [ADDR_W-1:0] in_addr;
    btn_state_t        cur_state, nxt_state;
    event_t            upd_event;
    phase_t            res_phase;
    event_t            res_event;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 8'd2;
            long_reg     <= 8'd50;
            repeat_reg   <= 8'd10;
            double_reg   <= 8'd15;
            active_reg   <= 8'd0;
            long_rel_reg <= 1'b0;
            delayed_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_LONG:     long_reg     <= cfg_data;
                CFG_REPEAT:   repeat_reg   <= cfg_data;
                CFG_DOUBLE:   double_reg   <= cfg_data;
                CFG_ACTIVE:   active_reg   <= cfg_data;
                CFG_LONG_REL: long_rel_reg <= cfg_data[0];
                CFG_DELAYED:  delayed_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg.debounce_ticks  = debounce_reg;
    assign cfg.long_ticks      = long_reg;
    assign cfg.repeat_ticks    = repeat_reg;
    assign cfg.double_ticks    = double_reg;
    assign cfg.long_on_release = long_rel_reg;
    assign cfg.delayed_single  = delayed_reg;

    // Handshake and input decode
    assign in_button = s_tdata[2:0];
    assign in_level  = s_tdata[3];
    assign in_addr   = ADDR_W'(in_button);
    assign in_range  = (32'(in_button) < NUM_BUTTONS);
    assign out_room  = !m_valid_reg || m_tready;
    assign s1_fire   = s1_valid_reg && out_room;
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign s1_addr   = ADDR_W'(s1_button_reg);
    assign mem_we    = s1_fire && s1_in_range_reg;

    // Memory read port, registered data
    always_ff @(posedge clk)
    begin
        if (s_fire)
            rd_data_reg <= mem[in_addr];
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[s1_addr] <= nxt_state;
    end

    // Valid bits, read valid and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            wb_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                entry_valid_reg[s1_addr] <= 1'b1;
                wb_valid_reg             <= 1'b1;
            end
            if (s_fire)
                rd_valid_reg <= entry_valid_reg[in_addr];
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (out_room)
                m_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_button_reg   <= in_button;
            s1_level_reg    <= in_level;
            s1_in_range_reg <= in_range;
        end
        if (mem_we)
        begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= nxt_state;
        end
        if (s1_fire)
            m_data_reg <= {res_phase, res_event, s1_button_reg};
    end

    // Current record: forwarded write, memory word, or reset state
    always_comb
    begin
        if (wb_valid_reg && wb_addr_reg == s1_addr)
            cur_state = wb_data_reg;
        else if (rd_valid_reg)
            cur_state = rd_data_reg;
        else
            cur_state = '0;
    end

    bed_update u_update (
        .cur          (cur_state),
        .level        (s1_level_reg),
        .active_level (active_reg[s1_button_reg]),
        .cfg          (cfg),
        .nxt          (nxt_state),
        .event_res    (upd_event)
    );

    // Ticks for absent buttons report nothing
    assign res_event = s1_in_range_reg ? upd_event : EV_NONE;
    assign res_phase = s1_in_range_reg ? nxt_state.phase : PH_IDLE;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A write-back only happens when the result has room to leave
    a_wb_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> out_room)
        else $error("state written back while output stalled");

    // Input is held off only by a full, blocked update stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without cause");

    // A long release always leaves the button idle
    a_rel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5:3] == EV_LONG_REL) |-> (m_tdata[7:6] == PH_IDLE))
        else $error("long release without return to idle");

    // An accepted tick reaches the update stage on the next cycle
    a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> s1_valid_reg)
        else $error("accepted tick lost before update");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

// File: dv/button_event_checker.sv
// Scoreboard for the button event detector: tracks register writes, predicts and checks results.
`timescale 1ns / 100ps

module button_event_checker
    import bed_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [2:0] button, [3] level, [7:4] zero
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // [2:0] button_out, [5:3] event_res, [7:6] phase
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         errors,
    output int         pending
);

    // One result as it travels on m_tdata
    typedef struct packed {
        logic [1:0] phase;
        event_t     ev;
        logic [2:0] button;
    } tick_result_t;

    // Shadow of the timing and mode registers
    logic [7:0] deb_ticks;
    logic [7:0] long_ticks;
    logic [7:0] rep_ticks;
    logic [7:0] dbl_ticks;
    logic [7:0] active_q;
    logic       long_rel;
    logic       delayed;

    // Shadow of the per-button state
    logic       lvl_q   [NUM_BUTTONS];
    logic [7:0] deb_q   [NUM_BUTTONS];
    phase_t     ph_q    [NUM_BUTTONS];
    prior_t     prior_q [NUM_BUTTONS];
    kind_t      kind_q  [NUM_BUTTONS];
    logic [7:0] hold_q  [NUM_BUTTONS];
    logic [7:0] rep_q   [NUM_BUTTONS];
    logic [7:0] gap_q   [NUM_BUTTONS];

    tick_result_t predicted_results[$];

    // Counter step that sticks at all ones
    function automatic logic [7:0] bump(input logic [7:0] v);
        if (v == SAT_MAX)
            return v;
        return v + 8'd1;
    endfunction

    // Apply one poll tick to the shadow state and return the result it yields
    function automatic tick_result_t poll_button(input logic [2:0] b, input logic lvl);
        tick_result_t r;
        logic [7:0]   c;
        r.button = b;
        r.ev     = EV_NONE;
        r.phase  = PH_IDLE;
        if (int'(b) >= NUM_BUTTONS)
            return r;

        // debounce: only differing ticks count
        if (lvl != lvl_q[b])
        begin
            c = bump(deb_q[b]);
            deb_q[b] = c;
            if (c >= deb_ticks)
            begin
                lvl_q[b] = lvl;
                deb_q[b] = 8'd0;
                if (ph_q[b] == PH_IDLE || ph_q[b] == PH_WAIT)
                    ph_q[b] = PH_DOWN;
                else if (ph_q[b] == PH_DOWN)
                    ph_q[b] = PH_UP;
            end
        end

        case (ph_q[b])
            PH_DOWN:
            begin
                if (lvl_q[b] == active_q[b])
                begin
                    // once long, stays long until release
                    if (kind_q[b] != PK_LONG)
                        kind_q[b] = PK_SHORT;
                    hold_q[b] = bump(hold_q[b]);
                    if (hold_q[b] >= long_ticks)
                    begin
                        if (long_rel)
                            kind_q[b] = PK_LONG;
                        else
                        begin
                            rep_q[b] = bump(rep_q[b]);
                            if (rep_q[b] >= rep_ticks)
                            begin
                                rep_q[b]  = 8'd0;
                                kind_q[b] = PK_LONG;
                                r.ev      = EV_LONG;
                            end
                        end
                    end
                end
            end
            PH_UP:
            begin
                if (kind_q[b] == PK_SHORT)
                begin
                    hold_q[b] = 8'd0;
                    rep_q[b]  = 8'd0;
                    if (gap_q[b] <= dbl_ticks && prior_q[b] == PR_WAIT)
                    begin
                        kind_q[b]  = PK_DOUBLE;
                        r.ev       = EV_DOUBLE;
                        ph_q[b]    = PH_IDLE;
                        prior_q[b] = PR_NONE;
                    end
                    else
                    begin
                        gap_q[b] = 8'd0;
                        if (!delayed)
                            r.ev = EV_CLICK;
                        ph_q[b]    = PH_WAIT;
                        prior_q[b] = PR_WAIT;
                    end
                end
                else if (kind_q[b] == PK_LONG)
                begin
                    r.ev       = long_rel ? EV_LONG : EV_LONG_REL;
                    hold_q[b]  = 8'd0;
                    rep_q[b]   = 8'd0;
                    kind_q[b]  = PK_NONE;
                    ph_q[b]    = PH_IDLE;
                    prior_q[b] = PR_LONG;
                end
                else
                    ph_q[b] = PH_IDLE;    // nothing pending: back to idle quietly
            end
            PH_WAIT:
            begin
                gap_q[b] = bump(gap_q[b]);
                if (gap_q[b] >= dbl_ticks)
                begin
                    ph_q[b]    = PH_IDLE;
                    prior_q[b] = PR_NONE;
                    if (delayed)
                    begin
                        gap_q[b]   = 8'd0;
                        r.ev       = EV_CLICK;
                        prior_q[b] = PR_CLICK;
                    end
                end
            end
            default: ;
        endcase

        r.phase = ph_q[b];
        return r;
    endfunction

    // Follow every transaction on the three channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t want;
        tick_result_t got;
        if (!rst_n)
        begin
            deb_ticks  = 8'd2;
            long_ticks = 8'd50;
            rep_ticks  = 8'd10;
            dbl_ticks  = 8'd15;
            active_q   = 8'd0;
            long_rel   = 1'b0;
            delayed    = 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                lvl_q[i]   = 1'b0;
                deb_q[i]   = 8'd0;
                ph_q[i]    = PH_IDLE;
                prior_q[i] = PR_NONE;
                kind_q[i]  = PK_NONE;
                hold_q[i]  = 8'd0;
                rep_q[i]   = 8'd0;
                gap_q[i]   = 8'd0;
            end
            predicted_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE: deb_ticks  = cfg_data;
                    CFG_LONG:     long_ticks = cfg_data;
                    CFG_REPEAT:   rep_ticks  = cfg_data;
                    CFG_DOUBLE:   dbl_ticks  = cfg_data;
                    CFG_ACTIVE:   active_q   = cfg_data;
                    CFG_LONG_REL: long_rel   = cfg_data[0];
                    CFG_DELAYED:  delayed    = cfg_data[0];
                    default: ;
                endcase
            end

            // accepted poll ticks
            if (s_tvalid && s_tready)
                predicted_results.push_back(poll_button(s_tdata[2:0], s_tdata[3]));

            // accepted results
            if (m_tvalid && m_tready)
            begin
                got = tick_result_t'(m_tdata);
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result transaction: m_tdata %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.button != want.button)
                    begin
                        $error("button_out: expected %0d, got %0d", want.button, got.button);
                        errors++;
                    end
                    if (got.ev != want.ev)
                    begin
                        $error("event_res: expected %0d, got %0d", want.ev, got.ev);
                        errors++;
                    end
                    if (got.phase != want.phase)
                    begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        errors++;
                    end
                end
            end
            pending = predicted_results.size();
        end
    end

endmodule

// File: dv/tb_button_event_detector_top.sv
// Testbench top for the button event detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_button_event_detector_top;
    import bed_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [2:0] button, [3] level, [7:4] zero
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [2:0] button_out, [5:3] event_res, [7:6] phase
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int ticks_sent   = 0;

    // no random idling on either side while set
    logic steady = 1'b0;

    // what the stimulus believes is configured
    logic [7:0] deb;
    logic [7:0] lng;
    logic [7:0] rpt;
    logic [7:0] dbl;
    logic [7:0] act;

    // last level sent per button
    logic last_lvl [8];

    button_event_detector_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    button_event_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side backpressure
    always @(negedge clk)
        m_tready = steady || ($urandom_range(0, 99) >= 31);

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_button_event_detector_top failed");
                $finish;
            end
        end
    end

    // One register write transaction; cfg_valid is left high for the caller
    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Write all seven registers; mode bits carry random upper bits
    task automatic set_config(input logic [7:0] d, input logic [7:0] l, input logic [7:0] r,
                              input logic [7:0] w, input logic [7:0] a,
                              input logic lr, input logic ds);
        deb = d;
        lng = l;
        rpt = r;
        dbl = w;
        act = a;
        write_reg(CFG_DEBOUNCE, d);
        write_reg(CFG_LONG, l);
        write_reg(CFG_REPEAT, r);
        write_reg(CFG_DOUBLE, w);
        write_reg(CFG_ACTIVE, a);
        write_reg(CFG_LONG_REL, {7'($urandom), lr});
        write_reg(CFG_DELAYED, {7'($urandom), ds});
        cfg_valid = 1'b0;
    endtask

    // One poll tick transaction, with random idle cycles ahead of it
    task automatic send_tick(input logic [2:0] b, input logic lvl);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, lvl, b};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        last_lvl[b] = lvl;
        ticks_sent++;
    endtask

    task automatic ticks(input logic [2:0] b, input logic lvl, input int n);
        repeat (n)
            send_tick(b, lvl);
    endtask

    // Hold one button at a level, with ticks of other buttons and bounces mixed in
    task automatic hold_level(input int b, input logic lvl, input int n);
        int other;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                other = $urandom_range(0, 7);
                send_tick(3'(other), last_lvl[other]);
            end
            if ($urandom_range(0, 99) < 4)
                send_tick(3'(b), !lvl);
            send_tick(3'(b), lvl);
        end
    endtask

    // A press and release on one button, sometimes a second press, sometimes noise
    task automatic gesture();
        int   b;
        logic down;
        int   press_len;
        b    = $urandom_range(0, 7);
        down = act[b];
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 6))
                send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                press_len = lng + deb + $urandom_range(0, 2 * rpt + 2);
            else
                press_len = deb + $urandom_range(1, lng);
            hold_level(b, down, press_len);
            hold_level(b, !down, deb + $urandom_range(1, dbl + 2));
            if ($urandom_range(0, 2) == 0)
            begin
                hold_level(b, down, deb + $urandom_range(1, lng));
                hold_level(b, !down, deb + $urandom_range(1, dbl + 2));
            end
        end
    endtask

    task automatic run_gestures(input int n);
        int target;
        target = ticks_sent + n;
        while (ticks_sent < target)
            gesture();
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = 8'd0;
        for (int i = 0; i < 8; i++)
            last_lvl[i] = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: click, double, long with repeats, change to the idle level, timeout
        set_config(8'd1, 8'd3, 8'd2, 8'd4, 8'h0F, 1'b0, 1'b0);
        ticks(3'd0, 1'b1, 2);
        ticks(3'd0, 1'b0, 2);
        ticks(3'd0, 1'b1, 2);
        ticks(3'd0, 1'b0, 2);
        ticks(3'd1, 1'b1, 6);
        ticks(3'd1, 1'b0, 1);
        ticks(3'd7, 1'b1, 1);
        ticks(3'd7, 1'b0, 1);
        ticks(3'd3, 1'b1, 2);
        ticks(3'd3, 1'b0, 6);
        drain();

        // random gestures under each mode pair, the first with no idling
        for (int m = 0; m < 5; m++)
        begin
            steady = (m == 0);
            set_config(8'($urandom_range(1, 3)), 8'($urandom_range(2, 12)),
                       8'($urandom_range(1, 4)), 8'($urandom_range(2, 10)), 8'($urandom),
                       (m < 4) ? m[0] : 1'($urandom), (m < 4) ? m[1] : 1'($urandom));
            run_gestures(220);
            drain();
        end
        steady = 1'b0;

        // timing values of one
        set_config(8'd1, 8'd1, 8'd1, 8'd1, 8'($urandom), 1'($urandom), 1'($urandom));
        run_gestures(100);
        drain();

        // zero timing values: events fire on the first qualifying tick
        set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'($urandom), 1'($urandom), 1'($urandom));
        run_gestures(80);
        drain();

        // largest timing values (long threshold 254), random ticks
        set_config(8'd255, 8'd254, 8'd255, 8'd255, 8'hAA, 1'($urandom), 1'($urandom));
        repeat (60)
            send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        drain();

        // hold counter saturation, then a click whose wait window runs out
        set_config(8'd1, 8'd254, 8'd1, 8'd255, 8'hFF, 1'b0, 1'b0);
        ticks(3'd5, 1'b0, 3);
        ticks(3'd5, 1'b1, 300);
        ticks(3'd5, 1'b0, 2);
        ticks(3'd5, 1'b1, 2);
        ticks(3'd5, 1'b0, 260);
        drain();

        if (errors == 0)
            $display("tb_button_event_detector_top passed");
        else
            $display("tb_button_event_detector_top failed");
        $finish;
    end

endmodule
